// File: src/bpfa_pkg.sv
// Shared constants, types and operation codes for the bitmap page frame allocator.
// No dependencies; imported by every module of the block.
package bpfa_pkg;

    // Default frame capacity of the map
    localparam int MAX_FRAMES_DEF = 65536;

    // Map word geometry: one 32-frame word per memory entry
    localparam int WORD_W = 32;
    localparam int OFF_W  = 5;

    // Field widths fixed by the interface
    localparam int FUNC_W    = 3;
    localparam int CNT_W     = 17;
    localparam int FRAME_W   = 16;
    localparam int POS_MIN_W = 18;   // first_frame + run_length needs 18 bits

    localparam logic [CNT_W-1:0] FRAME_COUNT_RST = 17'd65536;

    // Operation codes carried by the func field
    typedef enum logic [FUNC_W-1:0] {
        F_INIT      = 3'd0,
        F_REQUEST   = 3'd1,
        F_LOCK      = 3'd2,
        F_FREE      = 3'd3,
        F_RESERVE   = 3'd4,
        F_UNRESERVE = 3'd5
    } t_func;

    // Outcome of processing one map word
    typedef struct packed {
        logic [WORD_W-1:0] new_word;  // word to write back
        logic              any;       // at least one candidate bit in range
        logic [OFF_W-1:0]  low_idx;   // lowest candidate bit
        logic [OFF_W:0]    cnt;       // number of bits flipped
        logic              more;      // the range continues past this word
    } t_word_res;

endpackage

// File: src/bpfa_word_op.sv
// Per-word modify logic: range mask, candidate bits, lowest hit and flip count.
// Depends on bpfa_pkg.
module bpfa_word_op
    import bpfa_pkg::*;
#(
    parameter int POS_W = POS_MIN_W
) (
    input  logic [WORD_W-1:0] i_word,
    input  logic [POS_W-1:0]  i_pos,
    input  logic [POS_W-1:0]  i_end,
    input  logic [FUNC_W-1:0] i_func,
    output t_word_res         o_res,
    output logic [POS_W-1:0]  o_next_pos
);

    logic [POS_W-1:0]  base;
    logic [POS_W-1:0]  bound;
    logic [POS_W-1:0]  lim;
    logic [POS_W-1:0]  span;
    logic [OFF_W:0]    hi_off;
    logic [WORD_W-1:0] mask_lo;
    logic [WORD_W-1:0] mask_hi;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] cand;
    logic [WORD_W-1:0] low_bit;
    logic [WORD_W-1:0] changed;
    logic [OFF_W-1:0]  idx;
    logic              is_req;
    logic              setting;
    logic [1:0]        pc1 [16];
    logic [2:0]        pc2 [8];
    logic [3:0]        pc3 [4];
    logic [4:0]        pc4 [2];

    // Frames of this word that lie in [pos, min(end, word boundary))
    always_comb begin
        base    = {i_pos[POS_W-1:OFF_W], OFF_W'(0)};
        bound   = base + POS_W'(WORD_W);
        lim     = (i_end < bound) ? i_end : bound;
        span    = lim - base;
        hi_off  = span[OFF_W:0];
        mask_lo = {WORD_W{1'b1}} << i_pos[OFF_W-1:0];
        mask_hi = hi_off[OFF_W] ? {WORD_W{1'b1}}
                                : ((WORD_W'(1) << hi_off[OFF_W-1:0]) - WORD_W'(1));
        mask    = mask_lo & mask_hi;
    end

    // Bits that would change; a request takes only the lowest clear one
    always_comb begin
        is_req  = (i_func == F_REQUEST);
        setting = is_req || (i_func == F_LOCK) || (i_func == F_RESERVE);
        cand    = setting ? (mask & ~i_word) : (mask & i_word);
        low_bit = cand & (~cand + WORD_W'(1));
        changed = is_req ? low_bit : cand;
    end

    // One-hot to index of the lowest candidate
    always_comb begin
        idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            idx = idx | (low_bit[i] ? OFF_W'(i) : OFF_W'(0));
        end
    end

    // Population count of flipped bits as an adder tree
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            pc1[i] = {1'b0, changed[2*i]} + {1'b0, changed[2*i+1]};
        end
        for (int i = 0; i < 8; i++) begin
            pc2[i] = {1'b0, pc1[2*i]} + {1'b0, pc1[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            pc3[i] = {1'b0, pc2[2*i]} + {1'b0, pc2[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            pc4[i] = {1'b0, pc3[2*i]} + {1'b0, pc3[2*i+1]};
        end
    end

    assign o_res.new_word = i_word ^ changed;
    assign o_res.any      = |cand;
    assign o_res.low_idx  = idx;
    assign o_res.cnt      = {1'b0, pc4[0]} + {1'b0, pc4[1]};
    assign o_res.more     = (bound < i_end);
    assign o_next_pos     = bound;

endmodule

// File: src/bitmap_page_frame_allocator.sv
// Channel   | Direction | Handshake                | Payload
// cfg       | in        | i_cfg_valid / o_cfg_ready | i_cfg_frame_count
// in        | in        | i_in_valid / o_in_stall   | i_func, i_first_frame, i_run_length
// out       | out       | o_out_valid / i_out_stall | o_granted, o_granted_frame, counters
//
// The map lives in one memory of 32-frame words; each cycle of work reads one word,
// so a request reads each word scanned from the hint in turn, and a run op each word
// touched. Init clears the map with one word per cycle and then hands over a result.
// After reset the same clearing pass runs with the input stalled, but shows no result.
// A stalled output holds the next result in the core; the next item is taken once the
// finished result is registered.
// Top level of the bitmap page frame allocator. Depends on bpfa_pkg and bpfa_word_op.
module bitmap_page_frame_allocator
    import bpfa_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CNT_W-1:0]   i_cfg_frame_count,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [FRAME_W-1:0] i_first_frame,
    input  logic [CNT_W-1:0]   i_run_length,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_granted,
    output logic [FRAME_W-1:0] o_granted_frame,
    output logic [CNT_W-1:0]   o_free_frames,
    output logic [CNT_W-1:0]   o_used_frames,
    output logic [CNT_W-1:0]   o_reserved_frames
);

    localparam int DEPTH   = (MAX_FRAMES + WORD_W - 1) / WORD_W;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW      = (AW + OFF_W > POS_MIN_W) ? AW + OFF_W : POS_MIN_W;
    localparam int COV_CAP = (MAX_FRAMES > (2**CNT_W - 1)) ? (2**CNT_W - 1) : MAX_FRAMES;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_RUN   = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // Control state
    t_state             r_state, n_state;
    logic [AW-1:0]      r_sweep, n_sweep;
    logic               r_init_sweep, n_init_sweep;
    logic [CNT_W-1:0]   r_frame_count, n_frame_count;
    logic [CNT_W-1:0]   r_hint, n_hint;
    logic [CNT_W-1:0]   r_free, n_free;
    logic [CNT_W-1:0]   r_used, n_used;
    logic [CNT_W-1:0]   r_resv, n_resv;
    logic               r_out_valid, n_out_valid;

    // Working and result payload
    logic [FUNC_W-1:0]  r_op, n_op;
    logic [PW-1:0]      r_pos, n_pos;
    logic [PW-1:0]      r_end, n_end;
    logic               r_granted, n_granted;
    logic [FRAME_W-1:0] r_gframe, n_gframe;
    logic               r_out_granted, n_out_granted;
    logic [FRAME_W-1:0] r_out_gframe, n_out_gframe;
    logic [CNT_W-1:0]   r_out_free, n_out_free;
    logic [CNT_W-1:0]   r_out_used, n_out_used;
    logic [CNT_W-1:0]   r_out_resv, n_out_resv;

    // Map memory
    logic [WORD_W-1:0]  r_mem [DEPTH];
    logic [WORD_W-1:0]  r_rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;

    // Helpers
    t_word_res          res;
    logic [PW-1:0]      next_pos;
    logic [CNT_W-1:0]   covered;
    logic [PW-1:0]      run_start;
    logic [PW-1:0]      run_raw_end;
    logic [PW-1:0]      run_end;
    logic [PW-1:0]      low_frame;
    logic [CNT_W-1:0]   cnt_ext;
    logic               in_acc;
    logic               out_room;
    logic               clearing;

    bpfa_word_op #(
        .POS_W (PW)
    ) u_word_op (
        .i_word     (r_rd_data),
        .i_pos      (r_pos),
        .i_end      (r_end),
        .i_func     (r_op),
        .o_res      (res),
        .o_next_pos (next_pos)
    );

    // Memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Handshake outputs
    assign o_cfg_ready       = 1'b1;
    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_granted         = r_out_granted;
    assign o_granted_frame   = r_out_gframe;
    assign o_free_frames     = r_out_free;
    assign o_used_frames     = r_out_used;
    assign o_reserved_frames = r_out_resv;

    // Decoded quantities
    always_comb begin
        covered     = (r_frame_count < CNT_W'(COV_CAP)) ? r_frame_count : CNT_W'(COV_CAP);
        run_start   = PW'(i_first_frame);
        run_raw_end = PW'(i_first_frame) + PW'(i_run_length);
        run_end     = (run_raw_end < PW'(covered)) ? run_raw_end : PW'(covered);
        low_frame   = {r_pos[PW-1:OFF_W], res.low_idx};
        cnt_ext     = CNT_W'(res.cnt);
        in_acc      = i_in_valid && (r_state == S_IDLE);
        out_room    = !r_out_valid || !i_out_stall;
        clearing    = (r_op == F_FREE) || (r_op == F_UNRESERVE);
    end

    // Sequencer: accept, scan/modify words, clear sweep, hand over result
    always_comb begin
        n_state       = r_state;
        n_sweep       = r_sweep;
        n_init_sweep  = r_init_sweep;
        n_frame_count = r_frame_count;
        n_hint        = r_hint;
        n_free        = r_free;
        n_used        = r_used;
        n_resv        = r_resv;
        n_out_valid   = r_out_valid;
        n_op          = r_op;
        n_pos         = r_pos;
        n_end         = r_end;
        n_granted     = r_granted;
        n_gframe      = r_gframe;
        n_out_granted = r_out_granted;
        n_out_gframe  = r_out_gframe;
        n_out_free    = r_out_free;
        n_out_used    = r_out_used;
        n_out_resv    = r_out_resv;
        wr_en         = 1'b0;
        wr_addr       = r_pos[AW+OFF_W-1:OFF_W];
        wr_data       = res.new_word;
        rd_en         = 1'b0;

        if (i_cfg_valid) begin
            n_frame_count = i_cfg_frame_count;
        end
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_sweep;
                wr_data = '0;
                if (r_sweep == LAST_ADDR) begin
                    n_state      = r_init_sweep ? S_DONE : S_IDLE;
                    n_init_sweep = 1'b0;
                end else begin
                    n_sweep = r_sweep + AW'(1);
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_op      = i_func;
                    n_granted = 1'b0;
                    n_gframe  = '0;
                    n_state   = S_DONE;
                    unique case (i_func)
                        F_INIT: begin
                            n_free       = r_frame_count;
                            n_sweep      = '0;
                            n_init_sweep = 1'b1;
                            n_state      = S_CLEAR;
                        end
                        F_REQUEST: begin
                            if (r_hint < covered) begin
                                n_pos   = PW'(r_hint);
                                n_end   = PW'(covered);
                                rd_en   = 1'b1;
                                n_state = S_RUN;
                            end
                        end
                        F_LOCK, F_FREE, F_RESERVE, F_UNRESERVE: begin
                            if (run_start < run_end) begin
                                n_pos   = run_start;
                                n_end   = run_end;
                                rd_en   = 1'b1;
                                n_state = S_RUN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RUN: begin
                wr_en = 1'b1;
                if (r_op == F_REQUEST) begin
                    if (res.any) begin
                        n_free    = r_free - CNT_W'(1);
                        n_used    = r_used + CNT_W'(1);
                        n_hint    = low_frame[CNT_W-1:0];
                        n_granted = 1'b1;
                        n_gframe  = low_frame[FRAME_W-1:0];
                        n_state   = S_DONE;
                    end else if (res.more) begin
                        n_pos = next_pos;
                        rd_en = 1'b1;
                    end else begin
                        // nothing free up to the covered size
                        n_hint  = r_end[CNT_W-1:0];
                        n_state = S_DONE;
                    end
                end else begin
                    unique case (r_op)
                        F_LOCK: begin
                            n_free = r_free - cnt_ext;
                            n_used = r_used + cnt_ext;
                        end
                        F_RESERVE: begin
                            n_free = r_free - cnt_ext;
                            n_resv = r_resv + cnt_ext;
                        end
                        F_FREE: begin
                            n_free = r_free + cnt_ext;
                            n_used = r_used - cnt_ext;
                        end
                        F_UNRESERVE: begin
                            n_free = r_free + cnt_ext;
                            n_resv = r_resv - cnt_ext;
                        end
                        default: begin
                        end
                    endcase
                    // a cleared frame below the hint pulls it down
                    if (clearing && res.any && (low_frame < PW'(r_hint))) begin
                        n_hint = low_frame[CNT_W-1:0];
                    end
                    if (res.more) begin
                        n_pos = next_pos;
                        rd_en = 1'b1;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_room) begin
                    n_out_valid   = 1'b1;
                    n_out_granted = r_granted;
                    n_out_gframe  = r_gframe;
                    n_out_free    = r_free;
                    n_out_used    = r_used;
                    n_out_resv    = r_resv;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        rd_addr = n_pos[AW+OFF_W-1:OFF_W];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_sweep       <= '0;
            r_init_sweep  <= 1'b0;
            r_frame_count <= FRAME_COUNT_RST;
            r_hint        <= '0;
            r_free        <= '0;
            r_used        <= '0;
            r_resv        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_sweep       <= n_sweep;
            r_init_sweep  <= n_init_sweep;
            r_frame_count <= n_frame_count;
            r_hint        <= n_hint;
            r_free        <= n_free;
            r_used        <= n_used;
            r_resv        <= n_resv;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_pos         <= n_pos;
        r_end         <= n_end;
        r_granted     <= n_granted;
        r_gframe      <= n_gframe;
        r_out_granted <= n_out_granted;
        r_out_gframe  <= n_out_gframe;
        r_out_free    <= n_out_free;
        r_out_used    <= n_out_used;
        r_out_resv    <= n_out_resv;
    end

endmodule

// File: src/bpfa_check.sv
// Port-level checks for the bitmap page frame allocator, bound to the top level.
// Depends on bpfa_pkg and bitmap_page_frame_allocator.
module bpfa_check
    import bpfa_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic               o_granted,
    input logic [FRAME_W-1:0] o_granted_frame,
    input logic [CNT_W-1:0]   o_free_frames,
    input logic [CNT_W-1:0]   o_used_frames,
    input logic [CNT_W-1:0]   o_reserved_frames
);

    // A result without a grant reports frame zero
    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_granted |-> o_granted_frame == '0)
        else $error("granted_frame not zero without a grant");

    // A held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_granted)
            && $stable(o_granted_frame) && $stable(o_free_frames)
            && $stable(o_used_frames) && $stable(o_reserved_frames))
        else $error("stalled result changed");

    // Leaving reset: no result shown and the map clearing pass holds off items
    a_reset_exit: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid && o_in_stall)
        else $error("bad state on leaving reset");

    // A new result only appears while an item was in flight
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared with no item in flight");

endmodule

bind bitmap_page_frame_allocator bpfa_check u_bpfa_check (.*);
